/* rtl/core/jpeg_block_coefficient_expander_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the coefficient expander checkers.
// ----------------------------------------------------------------------------
`ifndef JPEG_BLOCK_COEFFICIENT_EXPANDER_CORE_ASSERT_SVH
`define JPEG_BLOCK_COEFFICIENT_EXPANDER_CORE_ASSERT_SVH

// Same-cycle implication.
`define JBCE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("Same-cycle implication failed.");

// Next-cycle implication.
`define JBCE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("Next-cycle implication failed.");

`endif

/* rtl/core/jbce_pkg.sv */
// ----------------------------------------------------------------------------
// Coefficient expander package
// Transaction types, constants, sequencer states and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jbce_pkg;

	localparam int COMPONENTS  = 4;
	localparam int BLOCK_LEN   = 64;
	localparam int DC_MAX_SIZE = 11;
	localparam int BAD_AC_SIZE = 11;
	localparam int ZRL_LEN     = 16;

	localparam logic [7:0] SYM_EOB = 8'h00;
	localparam logic [7:0] SYM_ZRL = 8'hF0;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	typedef struct packed {
		logic        is_dc;
		logic [1:0]  component;
		logic [7:0]  symbol;
		logic [14:0] amplitude_bits;
	} in_t;

	typedef struct packed {
		logic signed [15:0] coefficient;
		logic [5:0]         position;
		logic               last;
		logic               block_done;
		logic               error;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DCSUM,
		ST_RUN,
		ST_COEF,
		ST_ERR
	} state_t;

	function automatic logic [14:0] amp_mask(input logic [3:0] size);
		logic [15:0] m;
		m = (16'd1 << size) - 16'd1;
		return m[14:0];
	endfunction

	// Offset 1 - 2^size that turns a positive-looking code into a negative value.
	function automatic logic signed [17:0] neg_offset(input logic [3:0] size);
		logic [17:0] p;
		p = 18'd1 << size;
		return $signed(18'd1 - p);
	endfunction

endpackage

/* rtl/core/jpeg_block_coefficient_expander_core.sv */
// ----------------------------------------------------------------------------
// JPEG block coefficient expander
// Expands decoded run-length symbols into the 64 zigzag coefficients of a block.
// ----------------------------------------------------------------------------
// An accepted item is decoded, passes the DC predictor add if it is a DC item,
// and then has its results registered one per cycle while out_stall is low. An
// item yields up to 63 results; the next item is taken only after its last result.
// The amplitude decode and the DC predictor add share one 18-bit adder.
// Reset clears the sequencer, closes the block and zeroes every DC predictor.
`timescale 1ns / 1ps

module jpeg_block_coefficient_expander_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  jbce_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output jbce_pkg::out_t  out_data
);

	jbce_pkg::state_t state_q, state_d;
	jbce_pkg::in_t    item_q;
	jbce_pkg::out_t   out_q, out_next;
	logic             out_valid_q;

	logic [6:0]         npos_q;
	logic [6:0]         cnt_q;
	logic               final_q;
	logic               coef_q;
	logic signed [15:0] val_q;
	logic signed [15:0] pred_q [jbce_pkg::COMPONENTS];

	logic               out_free;
	logic               out_load;
	logic signed [17:0] alu_a, alu_b, alu_sum;
	logic signed [15:0] sat_sum;

	logic [3:0]  size;
	logic [3:0]  run;
	logic [14:0] amp_v;
	logic        amp_top;
	logic        dec_err;
	logic [6:0]  dec_cnt;
	logic        dec_final;
	logic        dec_coef;
	logic [6:0]  run_end;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign size    = item_q.symbol[3:0] & jbce_pkg::NIBBLE_MASK;
	assign run     = item_q.symbol[7:4];
	assign amp_v   = item_q.amplitude_bits & jbce_pkg::amp_mask(size);
	assign amp_top = |(amp_v & ~(jbce_pkg::amp_mask(size) >> 1));
	assign run_end = npos_q + 7'(run);

	assign alu_sum = alu_a + alu_b;

	always_comb begin
		if (alu_sum > 18'sd32767) begin
			sat_sum = 16'sd32767;
		end else if (alu_sum < -18'sd32768) begin
			sat_sum = -16'sd32768;
		end else begin
			sat_sum = alu_sum[15:0];
		end
	end

	// Symbol classification for the decode step.
	always_comb begin
		dec_err   = 1'b0;
		dec_cnt   = '0;
		dec_final = 1'b0;
		dec_coef  = 1'b0;
		if (item_q.is_dc) begin
			dec_err = (item_q.symbol > 8'(jbce_pkg::DC_MAX_SIZE)) ||
				(32'(item_q.component) >= jbce_pkg::COMPONENTS);
		end else if (npos_q >= 7'(jbce_pkg::BLOCK_LEN)) begin
			dec_err = 1'b1;
		end else if (item_q.symbol == jbce_pkg::SYM_EOB) begin
			dec_cnt   = 7'(jbce_pkg::BLOCK_LEN) - npos_q;
			dec_final = 1'b1;
		end else if (item_q.symbol == jbce_pkg::SYM_ZRL) begin
			dec_err   = npos_q > 7'(jbce_pkg::BLOCK_LEN - jbce_pkg::ZRL_LEN);
			dec_cnt   = 7'(jbce_pkg::ZRL_LEN);
			dec_final = 1'b1;
		end else begin
			dec_err  = (size == 4'd0) || (size == 4'(jbce_pkg::BAD_AC_SIZE)) ||
				(run_end >= 7'(jbce_pkg::BLOCK_LEN));
			dec_cnt  = 7'(run);
			dec_coef = 1'b1;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			jbce_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = jbce_pkg::ST_DECODE;
				end
			end
			jbce_pkg::ST_DECODE: begin
				priority if (dec_err) begin
					state_d = jbce_pkg::ST_ERR;
				end else if (item_q.is_dc) begin
					state_d = jbce_pkg::ST_DCSUM;
				end else if (dec_cnt != 7'd0) begin
					state_d = jbce_pkg::ST_RUN;
				end else begin
					state_d = jbce_pkg::ST_COEF;
				end
			end
			jbce_pkg::ST_DCSUM: begin
				state_d = jbce_pkg::ST_COEF;
			end
			jbce_pkg::ST_RUN: begin
				if (out_free && cnt_q == 7'd1) begin
					state_d = coef_q ? jbce_pkg::ST_COEF : jbce_pkg::ST_IDLE;
				end
			end
			jbce_pkg::ST_COEF, jbce_pkg::ST_ERR: begin
				if (out_free) begin
					state_d = jbce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = jbce_pkg::ST_IDLE;
			end
		endcase
	end

	// Output and datapath control.
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		out_next = '0;
		alu_a    = '0;
		alu_b    = '0;
		unique case (state_q)
			jbce_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			jbce_pkg::ST_DECODE: begin
				alu_a = $signed({3'b000, amp_v});
				alu_b = amp_top ? 18'sd0 : jbce_pkg::neg_offset(size);
			end
			jbce_pkg::ST_DCSUM: begin
				alu_a = 18'(pred_q[item_q.component]);
				alu_b = 18'(val_q);
			end
			jbce_pkg::ST_RUN: begin
				out_load            = out_free;
				out_next.position   = npos_q[5:0];
				out_next.last       = final_q && (cnt_q == 7'd1);
				out_next.block_done = (npos_q == 7'(jbce_pkg::BLOCK_LEN - 1));
			end
			jbce_pkg::ST_COEF: begin
				out_load             = out_free;
				out_next.coefficient = val_q;
				out_next.position    = npos_q[5:0];
				out_next.last        = 1'b1;
				out_next.block_done  = (npos_q == 7'(jbce_pkg::BLOCK_LEN - 1));
			end
			jbce_pkg::ST_ERR: begin
				out_load          = out_free;
				out_next.position = npos_q[6] ? 6'd0 : npos_q[5:0];
				out_next.last     = 1'b1;
				out_next.error    = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jbce_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			npos_q      <= 7'(jbce_pkg::BLOCK_LEN);
			cnt_q       <= '0;
			final_q     <= 1'b0;
			coef_q      <= 1'b0;
			for (int i = 0; i < jbce_pkg::COMPONENTS; i++) begin
				pred_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				jbce_pkg::ST_DECODE: begin
					cnt_q   <= dec_cnt;
					final_q <= dec_final;
					coef_q  <= dec_coef;
					if (item_q.is_dc) begin
						npos_q <= 7'(jbce_pkg::BLOCK_LEN);
					end
				end
				jbce_pkg::ST_DCSUM: begin
					pred_q[item_q.component] <= sat_sum;
					npos_q <= '0;
				end
				jbce_pkg::ST_RUN, jbce_pkg::ST_COEF: begin
					if (out_load) begin
						npos_q <= npos_q + 7'd1;
						cnt_q  <= cnt_q - 7'd1;
					end
				end
				jbce_pkg::ST_ERR: begin
					if (out_load) begin
						npos_q <= 7'(jbce_pkg::BLOCK_LEN);
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == jbce_pkg::ST_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (state_q == jbce_pkg::ST_DECODE) begin
			val_q <= alu_sum[15:0];
		end else if (state_q == jbce_pkg::ST_DCSUM) begin
			val_q <= sat_sum;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

endmodule

/* rtl/core/jbce_checker.sv */
// ----------------------------------------------------------------------------
// Coefficient expander checker
// Port-level assertions on transactions of the coefficient expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "jpeg_block_coefficient_expander_core_assert.svh"

module jbce_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input jbce_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_stall,
	input jbce_pkg::out_t out_data
);

	logic in_acc;
	logic out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// A stalled input transaction holds until it is taken.
	`JBCE_ASSERT_NXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(in_data))

	// A stalled result holds until it is taken.
	`JBCE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// The block is busy right after it takes an input transaction.
	`JBCE_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_acc, in_stall)

	// Completing a block means position 63 and no error.
	`JBCE_ASSERT_IMP(a_done_pos, clk, arst_n, out_acc && out_data.block_done, out_data.position == 6'd63 && !out_data.error)

	// An error result is a lone zero result that closes its input.
	`JBCE_ASSERT_IMP(a_err_form, clk, arst_n, out_acc && out_data.error, out_data.last && out_data.coefficient == 16'sd0)

endmodule

bind jpeg_block_coefficient_expander_core jbce_checker u_jbce_checker (.*);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Coefficient expander testbench
// Drives DC items and AC run-length symbols into the expander and checks every
// coefficient transaction against a behavioral model of the block. Directed
// items cover the field extremes and error cases. Random blocks, noise and a
// DC saturation sweep follow, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int RANDOM_ITEMS   = 480;
	localparam int TAIL_ITEMS     = 60;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int SINK           = 1;
	localparam int SOURCE         = 0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	jbce_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	jbce_pkg::out_t out_data;

	jbce_pkg::in_t symbol_queue[$];
	jbce_pkg::out_t expected_coefs[$];
	int zz_next = jbce_pkg::BLOCK_LEN;
	logic signed [15:0] dc_base[jbce_pkg::COMPONENTS];
	int idle_stretch[2];
	int send_gap = 0;
	int stall_left = 0;
	int items_total = 0;
	int items_accepted = 0;
	int quiet_cycles = 0;
	bit failed = 1'b0;

	jpeg_block_coefficient_expander_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void add_item(input bit dc, input int comp, input int sym,
			input int amp);
		jbce_pkg::in_t it;
		it.is_dc = dc;
		it.component = 2'(comp);
		it.symbol = 8'(sym);
		it.amplitude_bits = 15'(amp);
		symbol_queue.push_back(it);
	endfunction

	function automatic int rand_amp();
		return $urandom_range(0, 32767);
	endfunction

	function automatic int rand_ac_size();
		int sz;
		sz = $urandom_range(1, 14);
		if (sz >= jbce_pkg::BAD_AC_SIZE)
			sz++;
		return sz;
	endfunction

	// One block with random content, which may end in a malformed symbol, or a piece of noise.
	function automatic void add_block();
		int p;
		int r;
		int run;
		int top;
		if ($urandom_range(0, 9) == 0) begin
			add_item($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 255),
				rand_amp());
			return;
		end
		add_item(1'b1, $urandom_range(0, 3), $urandom_range(0, jbce_pkg::DC_MAX_SIZE),
			rand_amp());
		p = 1;
		while (p < jbce_pkg::BLOCK_LEN) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				add_item(1'b0, $urandom_range(0, 3), jbce_pkg::SYM_EOB, rand_amp());
				return;
			end
			if (r < 16 && p + jbce_pkg::ZRL_LEN <= jbce_pkg::BLOCK_LEN) begin
				add_item(1'b0, $urandom_range(0, 3), jbce_pkg::SYM_ZRL, rand_amp());
				p += jbce_pkg::ZRL_LEN;
				continue;
			end
			if (r < 19) begin
				add_item(1'b0, $urandom_range(0, 3), $urandom_range(0, 255), rand_amp());
				return;
			end
			if (r < 24 && p > jbce_pkg::BLOCK_LEN - jbce_pkg::ZRL_LEN) begin
				run = $urandom_range(jbce_pkg::BLOCK_LEN - p, 15);
				add_item(1'b0, $urandom_range(0, 3), (run << 4) | $urandom_range(1, 10),
					rand_amp());
				return;
			end
			top = (jbce_pkg::BLOCK_LEN - 1 - p < 15) ? jbce_pkg::BLOCK_LEN - 1 - p : 15;
			run = ($urandom_range(0, 1) == 0) ? $urandom_range(0, top)
				: $urandom_range(0, (top < 3) ? top : 3);
			add_item(1'b0, $urandom_range(0, 3), (run << 4) | rand_ac_size(), rand_amp());
			p += run + 1;
		end
		if ($urandom_range(0, 3) == 0)
			add_item(1'b0, $urandom_range(0, 3), $urandom_range(1, 255), rand_amp());
	endfunction

	function automatic int idle_burst(input int side);
		if (symbol_queue.size() < TAIL_ITEMS)
			return 0;
		if (idle_stretch[side] > 0) begin
			idle_stretch[side]--;
			return 0;
		end
		idle_stretch[side] = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			: $urandom_range(0, 20);
		return $urandom_range(1, 14);
	endfunction

	function automatic int decode_amplitude(input int size, input int bits);
		int v;
		if (size == 0)
			return 0;
		v = bits & ((1 << size) - 1);
		if (((v >> (size - 1)) & 1) != 0)
			return v;
		return v - (1 << size) + 1;
	endfunction

	function automatic void push_result(input int coef, input int pos, input bit fin,
			input bit err);
		jbce_pkg::out_t r;
		r.coefficient = 16'(coef);
		r.position = 6'(pos);
		r.last = fin;
		r.block_done = !err && pos == jbce_pkg::BLOCK_LEN - 1;
		r.error = err;
		expected_coefs.push_back(r);
	endfunction

	function automatic void push_abandon();
		push_result(0, (zz_next < jbce_pkg::BLOCK_LEN) ? zz_next : 0, 1'b1, 1'b1);
		zz_next = jbce_pkg::BLOCK_LEN;
	endfunction

	function automatic void push_zeros(input int count, input bit fin);
		for (int i = 0; i < count; i++) begin
			push_result(0, zz_next, fin && i == count - 1, 1'b0);
			zz_next++;
		end
	endfunction

	function automatic void expand_symbol(input jbce_pkg::in_t it);
		int sum;
		int run;
		int sz;
		if (it.is_dc) begin
			zz_next = jbce_pkg::BLOCK_LEN;
			if (it.symbol > jbce_pkg::DC_MAX_SIZE || it.component >= jbce_pkg::COMPONENTS)
			begin
				push_abandon();
				return;
			end
			sum = int'(dc_base[it.component])
				+ decode_amplitude(int'(it.symbol), int'(it.amplitude_bits));
			if (sum > 32767)
				sum = 32767;
			if (sum < -32768)
				sum = -32768;
			dc_base[it.component] = 16'(sum);
			push_result(sum, 0, 1'b1, 1'b0);
			zz_next = 1;
			return;
		end
		if (zz_next >= jbce_pkg::BLOCK_LEN) begin
			push_abandon();
			return;
		end
		if (it.symbol == jbce_pkg::SYM_EOB) begin
			push_zeros(jbce_pkg::BLOCK_LEN - zz_next, 1'b1);
			return;
		end
		if (it.symbol == jbce_pkg::SYM_ZRL) begin
			if (zz_next + jbce_pkg::ZRL_LEN > jbce_pkg::BLOCK_LEN)
				push_abandon();
			else
				push_zeros(jbce_pkg::ZRL_LEN, 1'b1);
			return;
		end
		run = int'(it.symbol[7:4]);
		sz = int'(it.symbol[3:0]);
		if (sz == 0 || sz == jbce_pkg::BAD_AC_SIZE || zz_next + run >= jbce_pkg::BLOCK_LEN)
		begin
			push_abandon();
			return;
		end
		push_zeros(run, 1'b0);
		push_result(decode_amplitude(sz, int'(it.amplitude_bits)), zz_next, 1'b1, 1'b0);
		zz_next++;
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_symbols
		int gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!(in_valid && in_stall)) begin
			gap = (send_gap > 0) ? send_gap : idle_burst(SOURCE);
			if (gap > 0) begin
				send_gap = gap - 1;
				in_valid <= 1'b0;
			end else if (symbol_queue.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= symbol_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : drive_stall
		int n;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			n = idle_burst(SINK);
			if (n > 0) begin
				stall_left = n - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_coefs
		jbce_pkg::out_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expand_symbol(in_data);
				items_accepted++;
			end
			if (out_valid && !out_stall) begin
				if (expected_coefs.size() == 0) begin
					$error("unexpected transaction at position %0d", out_data.position);
					failed = 1'b1;
				end else begin
					want = expected_coefs.pop_front();
					if (out_data.coefficient !== want.coefficient) begin
						$error("coefficient: expected %0d, actual %0d", want.coefficient,
							out_data.coefficient);
						failed = 1'b1;
					end
					if (out_data.position !== want.position) begin
						$error("position: expected %0d, actual %0d", want.position,
							out_data.position);
						failed = 1'b1;
					end
					if (out_data.last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, out_data.last);
						failed = 1'b1;
					end
					if (out_data.block_done !== want.block_done) begin
						$error("block_done: expected %0b, actual %0b", want.block_done,
							out_data.block_done);
						failed = 1'b1;
					end
					if (out_data.error !== want.error) begin
						$error("error: expected %0b, actual %0b", want.error, out_data.error);
						failed = 1'b1;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int directed;
		for (int c = 0; c < jbce_pkg::COMPONENTS; c++)
			dc_base[c] = '0;
		idle_stretch[SOURCE] = 0;
		idle_stretch[SINK] = 0;

		add_item(1'b0, 0, 8'h11, 1);
		add_item(1'b1, 0, 0, 15'h7FFF);
		add_item(1'b1, 1, jbce_pkg::DC_MAX_SIZE, 15'h7FFF);
		add_item(1'b1, 1, jbce_pkg::DC_MAX_SIZE, 15'h0000);
		add_item(1'b1, 2, jbce_pkg::DC_MAX_SIZE + 1, 15'h0FFF);
		add_item(1'b1, 3, 8'hFF, 15'h5555);
		add_item(1'b1, 2, 1, 1);
		add_item(1'b0, 3, 8'h0F, 15'h7FFF);
		add_item(1'b0, 3, 8'h0F, 15'h0000);
		add_item(1'b0, 0, jbce_pkg::BAD_AC_SIZE, 15'h2AAA);
		add_item(1'b1, 3, 4, 8);
		add_item(1'b0, 0, 8'h10, 15'h7FFF);
		add_item(1'b1, 0, 2, 1);
		for (int i = 0; i < 4; i++)
			add_item(1'b0, 1, jbce_pkg::SYM_ZRL, 0);
		add_item(1'b1, 0, 0, 0);
		for (int i = 0; i < 3; i++)
			add_item(1'b0, 2, jbce_pkg::SYM_ZRL, 15'h7FFF);
		add_item(1'b0, 0, 8'hE1, 1);
		add_item(1'b0, 0, 8'h01, 1);
		add_item(1'b1, 1, 3, 5);
		add_item(1'b0, 0, jbce_pkg::SYM_EOB, 0);
		directed = symbol_queue.size();

		// Drive one predictor into positive and then negative saturation.
		for (int i = 0; i < 20; i++)
			add_item(1'b1, 2, jbce_pkg::DC_MAX_SIZE, ($urandom_range(0, 15) << 11) | 15'h07FF);
		for (int i = 0; i < 40; i++)
			add_item(1'b1, 2, jbce_pkg::DC_MAX_SIZE, $urandom_range(0, 15) << 11);
		while (symbol_queue.size() < directed + RANDOM_ITEMS)
			add_block();
		items_total = symbol_queue.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted < items_total)
			@(posedge clk);
		while (expected_coefs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
